/* rtl/phc_pkg.sv */
// phc_pkg: shared types and constants of the polynomial store
// no dependencies
`default_nettype none
package phc_pkg;

    localparam int COEF_W = 32;
    localparam int EXP_W  = 4;
    localparam int MODE_W = 2;

    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_EVAL   = 2'd3;

    typedef struct packed {
        logic init;
        logic step;
    } hrn_ctrl_t;

endpackage
`default_nettype wire

/* rtl/phc_cell.sv */
// phc_cell: one coefficient cell of the rotating store ring
// depends on phc_pkg
`default_nettype none
module phc_cell (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       clear,
    input  wire logic                       shift,
    input  wire logic [phc_pkg::COEF_W-1:0] din,
    output logic      [phc_pkg::COEF_W-1:0] dout
);
    import phc_pkg::*;

    logic [COEF_W-1:0] coef_reg;
    logic [COEF_W-1:0] coef_next;

    always_comb
    begin
        coef_next = coef_reg;
        if (clear)
        begin
            coef_next = '0;
        end
        else if (shift)
        begin
            coef_next = din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    assign dout = coef_reg;

endmodule
`default_nettype wire

/* rtl/phc_horner.sv */
// phc_horner: multiply-add accumulator fed by the ring tap
// depends on phc_pkg
`default_nettype none
module phc_horner (
    input  wire logic                       clk,
    input  wire phc_pkg::hrn_ctrl_t         ctrl,
    input  wire logic [phc_pkg::COEF_W-1:0] point,
    input  wire logic [phc_pkg::COEF_W-1:0] tap,
    output logic      [phc_pkg::COEF_W-1:0] acc_next
);
    import phc_pkg::*;

    logic [COEF_W-1:0] acc_reg;
    logic [COEF_W-1:0] prod;

    assign prod     = COEF_W'(acc_reg * point);
    assign acc_next = prod + tap;

    always_ff @(posedge clk)
    begin
        if (ctrl.init)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.step)
        begin
            acc_reg <= acc_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/polynomial_store_horner_eval_top.sv */
// polynomial_store_horner_eval_top: polynomial store with horner evaluation
// depends on phc_pkg, phc_cell, phc_horner
// clear: result the cycle after the transfer, next transfer in that cycle
// insert, query, evaluate: the coefficient ring rotates once, result strobe the
// cycle after its last shift; busy is high and no new item is taken while it rotates
// the multiply-add at the ring tap is combinational within each step; results cannot stall
// reset clears all coefficients and the degree at once
`default_nettype none
module polynomial_store_horner_eval_top #(
    parameter int MAX_TERMS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic        [phc_pkg::MODE_W-1:0] mode,
    input  wire logic        [phc_pkg::COEF_W-1:0] term_coef,
    input  wire logic        [phc_pkg::EXP_W-1:0]  term_exp,
    input  wire logic signed [phc_pkg::COEF_W-1:0] point_x,
    output logic                                   done,
    output logic signed      [phc_pkg::COEF_W-1:0] eval_value,
    output logic             [phc_pkg::COEF_W-1:0] coef_value,
    output logic             [phc_pkg::EXP_W-1:0]  poly_degree
);
    import phc_pkg::*;

    localparam int IDX_W = $clog2(MAX_TERMS);
    localparam int CMP_W = (IDX_W > EXP_W) ? IDX_W : EXP_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TERMS - 1);

    typedef enum logic {ST_IDLE, ST_RUN} state_t;

    state_t            state_reg;
    logic [IDX_W-1:0]  cnt_reg;
    logic [MODE_W-1:0] mode_reg;
    logic [COEF_W-1:0] coef_reg;
    logic [EXP_W-1:0]  exp_reg;
    logic [COEF_W-1:0] x_reg;
    logic [COEF_W-1:0] query_reg;
    logic [EXP_W-1:0]  degree_reg;
    logic              done_reg;
    logic [COEF_W-1:0] eval_reg;
    logic [COEF_W-1:0] coefv_reg;
    logic [EXP_W-1:0]  degv_reg;

    logic [COEF_W-1:0] chain [MAX_TERMS];
    logic [COEF_W-1:0] tap;
    logic [COEF_W-1:0] feedback;
    logic [COEF_W-1:0] acc_next;
    logic              accept;
    logic              running;
    logic              hit;
    logic              clear_all;
    hrn_ctrl_t         hctrl;

    assign accept    = start && (state_reg == ST_IDLE);
    assign running   = (state_reg == ST_RUN);
    assign clear_all = accept && (mode == MODE_CLEAR);
    assign tap       = chain[MAX_TERMS-1];
    assign hit       = (CMP_W'(cnt_reg) == CMP_W'(exp_reg));
    assign feedback  = (hit && (mode_reg == MODE_INSERT)) ? tap + coef_reg : tap;

    assign hctrl.init = accept;
    assign hctrl.step = running;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_TERMS; gi++)
        begin : g_cell
            phc_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .clear (clear_all),
                .shift (running),
                .din   ((gi == 0) ? feedback : chain[(gi == 0) ? 0 : gi - 1]),
                .dout  (chain[gi])
            );
        end
    endgenerate

    phc_horner u_horner (
        .clk      (clk),
        .ctrl     (hctrl),
        .point    (x_reg),
        .tap      (tap),
        .acc_next (acc_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            mode_reg   <= MODE_CLEAR;
            coef_reg   <= '0;
            exp_reg    <= '0;
            x_reg      <= '0;
            query_reg  <= '0;
            degree_reg <= '0;
            done_reg   <= 1'b0;
            eval_reg   <= '0;
            coefv_reg  <= '0;
            degv_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        mode_reg  <= mode;
                        coef_reg  <= term_coef;
                        exp_reg   <= term_exp;
                        x_reg     <= point_x;
                        query_reg <= '0;
                        cnt_reg   <= LAST_IDX;
                        if (mode == MODE_CLEAR)
                        begin
                            degree_reg <= '0;
                            eval_reg   <= '0;
                            coefv_reg  <= '0;
                            degv_reg   <= '0;
                            done_reg   <= 1'b1;
                        end
                        else
                        begin
                            if ((mode == MODE_INSERT) && (term_coef != '0)
                                && (32'(term_exp) < MAX_TERMS) && (term_exp > degree_reg))
                            begin
                                degree_reg <= term_exp;
                            end
                            state_reg <= ST_RUN;
                        end
                    end
                end
                ST_RUN:
                begin
                    if (hit && (mode_reg == MODE_QUERY))
                    begin
                        query_reg <= tap;
                    end
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        eval_reg  <= (mode_reg == MODE_EVAL) ? acc_next : '0;
                        coefv_reg <= (hit && (mode_reg == MODE_QUERY)) ? tap : query_reg;
                        degv_reg  <= degree_reg;
                        done_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy        = running;
    assign done        = done_reg;
    assign eval_value  = eval_reg;
    assign coef_value  = coefv_reg;
    assign poly_degree = degv_reg;

endmodule
`default_nettype wire
